// ===== rtl/brpa_pkg.sv =====
// Shared types, codes and constants of the bitmap region page allocator.
package brpa_pkg;

   localparam int PN_W     = 10;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // slots examined per cycle by the region search
   localparam int CHUNK   = 8;
   localparam int CHUNK_W = 3;

   // fixed-point shift of the reciprocal used to split a page number
   localparam int DIV_SHIFT = 20;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] RSP_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_BAD_FREE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_DIV,
      ST_SPLIT,
      ST_RD,
      ST_MOD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic pick;
      logic div;
      logic split;
      logic rd;
      logic modify;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              last_chunk;
      logic              found_avail;
      logic              free_hit;
      logic              out_free;
   } stat_type;

endpackage

// ===== rtl/bitmap_region_page_allocator_unit.sv =====
// Top level of the bitmap region page allocator: controller plus datapath.
//
// Page allocator over REGION_SLOTS region slots of PAGES_PER_REGION pages each; a page
// number is slot * PAGES_PER_REGION + index. A request beat carries a mode (allocate,
// free, ownership query) and a page number, and yields exactly one response beat.
// Allocate hands out the lowest free page of the lowest valid region that has one,
// otherwise opens the lowest unused slot and returns its page 0 (region_acquired), or
// answers no space. Free sets the page's bit again and releases the slot once the whole
// region is free (region_released); freeing into an absent region or an already free
// page answers bad free and changes nothing. Query answers whether the page lies in a
// valid region. One request is in flight at a time; a finished response sits in an
// output register, so the next request is taken while it waits. The region search of
// an allocate looks at eight slots a cycle; every other mode splits the page number
// into slot and index by a reciprocal multiply, registered in a divide step and then
// split. An existing region's bitmap costs a registered read and a write-back of the
// single-port mask memory. A response held by stall delays the return to idle. No
// clearing pass is needed after reset: only the valid and non-full flags are cleared,
// and a mask is always written when its slot opens.
module bitmap_region_page_allocator_unit #(
   parameter int REGION_SLOTS     = 16,
   parameter int PAGES_PER_REGION = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brpa_pkg::MODE_W-1:0]   req_mode,
   input  logic [brpa_pkg::PN_W-1:0]     req_page_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brpa_pkg::PN_W-1:0]     rsp_page_number_res,
   output logic [brpa_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_owned,
   output logic                          rsp_region_acquired,
   output logic                          rsp_region_released
);
   import brpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence each beat through search, split, read and write-back
   brpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold region flags, bitmaps and the response register
   brpa_datapath #(
      .REGION_SLOTS     (REGION_SLOTS),
      .PAGES_PER_REGION (PAGES_PER_REGION)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_page_number     (req_page_number),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_page_number_res (rsp_page_number_res),
      .rsp_status          (rsp_status),
      .rsp_owned           (rsp_owned),
      .rsp_region_acquired (rsp_region_acquired),
      .rsp_region_released (rsp_region_released),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

// ===== rtl/brpa_ctrl.sv =====
// Sequencer of the bitmap region page allocator.
module brpa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [brpa_pkg::MODE_W-1:0] req_mode,
   output logic                        req_stall,
   input  brpa_pkg::stat_type          stat,
   output brpa_pkg::cmd_type           cmd
);
   import brpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_ALLOC) ? ST_SCAN : ST_DIV;
            end
         end
         ST_SCAN:  state_in = stat.last_chunk ? ST_PICK : ST_SCAN;
         ST_PICK:  state_in = stat.found_avail ? ST_RD : ST_RESP;
         ST_DIV:   state_in = ST_SPLIT;
         ST_SPLIT: begin
            state_in = (stat.mode == MODE_FREE && stat.free_hit) ? ST_RD : ST_RESP;
         end
         ST_RD:    state_in = ST_MOD;
         ST_MOD:   state_in = ST_RESP;
         ST_RESP:  state_in = stat.out_free ? ST_IDLE : ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_PICK:  cmd.pick      = 1'b1;
         ST_DIV:   cmd.div       = 1'b1;
         ST_SPLIT: cmd.split     = 1'b1;
         ST_RD:    cmd.rd        = 1'b1;
         ST_MOD:   cmd.modify    = 1'b1;
         ST_RESP:  cmd.load      = stat.out_free;
         default:  cmd           = '0;
      endcase
   end

endmodule

// ===== rtl/brpa_datapath.sv =====
// Region bookkeeping, bitmap memory, search and result register of the allocator.
module brpa_datapath #(
   parameter int REGION_SLOTS     = 16,
   parameter int PAGES_PER_REGION = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [brpa_pkg::MODE_W-1:0]   req_mode,
   input  logic [brpa_pkg::PN_W-1:0]     req_page_number,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [brpa_pkg::PN_W-1:0]     rsp_page_number_res,
   output logic [brpa_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_owned,
   output logic                          rsp_region_acquired,
   output logic                          rsp_region_released,
   input  brpa_pkg::cmd_type             cmd,
   output brpa_pkg::stat_type            stat
);
   import brpa_pkg::*;

   localparam int SW    = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int PW    = PAGES_PER_REGION;
   localparam int BW    = $clog2(PAGES_PER_REGION);
   localparam int NCH   = (REGION_SLOTS + CHUNK - 1) / CHUNK;
   localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PADW  = NCH * CHUNK;
   localparam int PSW   = CW + CHUNK_W;
   localparam int RW    = DIV_SHIFT + 1;
   localparam int PRW   = PN_W + RW;
   localparam int PGW   = SW + PN_W;
   localparam logic [RW-1:0] RECIP =
      RW'(((1 << DIV_SHIFT) + PAGES_PER_REGION - 1) / PAGES_PER_REGION);
   localparam logic [PW-1:0] FULL_MASK = {PW{1'b1}};

   // bitmap store: one free mask per slot, a set bit marks a free page
   logic [PW-1:0] mask_ram [REGION_SLOTS];
   logic [PW-1:0] rd_data_ff;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [PN_W-1:0]         pn_ff, pn_in;
   logic [PN_W-1:0]         q_ff, q_in;
   logic [BW-1:0]           idx_ff, idx_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [BW-1:0]           bit_ff, bit_in;
   logic [CW-1:0]           chunk_ff, chunk_in;
   logic                    found_avail_ff, found_avail_in;
   logic                    found_empty_ff, found_empty_in;
   logic [PSW-1:0]          avail_slot_ff, avail_slot_in;
   logic [PSW-1:0]          empty_slot_ff, empty_slot_in;
   logic [REGION_SLOTS-1:0] valid_ff, valid_in;
   logic [REGION_SLOTS-1:0] nonfull_ff, nonfull_in;
   logic                    bad_ff, bad_in;
   logic                    nospace_ff, nospace_in;
   logic                    owned_ff, owned_in;
   logic                    acq_ff, acq_in;
   logic                    rel_ff, rel_in;
   logic                    page_en_ff, page_en_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PN_W-1:0]         rsp_page_ff, rsp_page_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_owned_ff, rsp_owned_in;
   logic                    rsp_acq_ff, rsp_acq_in;
   logic                    rsp_rel_ff, rsp_rel_in;

   logic                    mem_we;
   logic [SW-1:0]           mem_wa;
   logic [PW-1:0]           mem_wd;

   logic [PADW-1:0]         avail_pad, empty_pad;
   logic [CHUNK-1:0]        avail_slice, empty_slice;
   logic [CHUNK_W-1:0]      avail_enc, empty_enc;
   logic [SW-1:0]           sel_slot;
   logic                    in_range;
   logic                    free_hit;
   logic [PRW-1:0]          prod;
   logic [PN_W-1:0]         rem;
   logic [PW-1:0]           iso;
   logic [BW-1:0]           low_bit;
   logic [PW-1:0]           idx_bit;
   logic [PW-1:0]           new_mask;
   logic [PGW-1:0]          page_wide;

   // search slices and their lowest set positions
   always_comb begin
      avail_pad   = PADW'(valid_ff & nonfull_ff);
      empty_pad   = PADW'(~valid_ff);
      avail_slice = avail_pad[chunk_ff * CHUNK +: CHUNK];
      empty_slice = empty_pad[chunk_ff * CHUNK +: CHUNK];
      avail_enc   = '0;
      empty_enc   = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (avail_slice[i]) avail_enc = CHUNK_W'(i);
         if (empty_slice[i]) empty_enc = CHUNK_W'(i);
      end
   end

   always_comb begin
      sel_slot = found_avail_ff ? avail_slot_ff[SW-1:0] : empty_slot_ff[SW-1:0];
      in_range = (q_ff < PN_W'(REGION_SLOTS));
      free_hit = in_range ? valid_ff[q_ff[SW-1:0]] : 1'b0;
      prod     = PRW'(pn_ff) * PRW'(RECIP);
      rem      = pn_ff - PN_W'(q_ff * PN_W'(PAGES_PER_REGION));
      iso      = rd_data_ff & (~rd_data_ff + PW'(1));
      low_bit  = '0;
      for (int i = 0; i < PW; i++) begin
         if (iso[i]) low_bit = low_bit | BW'(i);
      end
      idx_bit  = PW'(1) << idx_ff;
      page_wide = PGW'(slot_ff) * PGW'(PAGES_PER_REGION) + PGW'(bit_ff);
   end

   always_comb begin
      mode_in        = mode_ff;
      pn_in          = pn_ff;
      q_in           = q_ff;
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      bit_in         = bit_ff;
      chunk_in       = chunk_ff;
      found_avail_in = found_avail_ff;
      found_empty_in = found_empty_ff;
      avail_slot_in  = avail_slot_ff;
      empty_slot_in  = empty_slot_ff;
      valid_in       = valid_ff;
      nonfull_in     = nonfull_ff;
      bad_in         = bad_ff;
      nospace_in     = nospace_ff;
      owned_in       = owned_ff;
      acq_in         = acq_ff;
      rel_in         = rel_ff;
      page_en_in     = page_en_ff;
      mem_we         = 1'b0;
      mem_wa         = slot_ff;
      mem_wd         = rd_data_ff;
      new_mask       = rd_data_ff;

      if (cmd.accept) begin
         mode_in        = req_mode;
         pn_in          = req_page_number;
         chunk_in       = '0;
         found_avail_in = 1'b0;
         found_empty_in = 1'b0;
         bad_in         = 1'b0;
         nospace_in     = 1'b0;
         owned_in       = 1'b0;
         acq_in         = 1'b0;
         rel_in         = 1'b0;
         page_en_in     = 1'b0;
         bit_in         = '0;
      end

      // keep the first hit of each kind, lowest chunk first
      if (cmd.scan_step) begin
         chunk_in = chunk_ff + CW'(1);
         if (!found_avail_ff && avail_slice != '0) begin
            found_avail_in = 1'b1;
            avail_slot_in  = {chunk_ff, avail_enc};
         end
         if (!found_empty_ff && empty_slice != '0) begin
            found_empty_in = 1'b1;
            empty_slot_in  = {chunk_ff, empty_enc};
         end
      end

      if (cmd.pick) begin
         slot_in = sel_slot;
         if (!found_avail_ff && found_empty_ff) begin
            // open a fresh region and hand out its page 0
            mem_we               = 1'b1;
            mem_wa               = sel_slot;
            mem_wd               = FULL_MASK & ~PW'(1);
            valid_in[sel_slot]   = 1'b1;
            nonfull_in[sel_slot] = 1'b1;
            acq_in               = 1'b1;
            page_en_in           = 1'b1;
            bit_in               = '0;
         end else if (!found_avail_ff) begin
            nospace_in = 1'b1;
         end
      end

      if (cmd.div) begin
         q_in = prod[DIV_SHIFT +: PN_W];
      end

      if (cmd.split) begin
         idx_in  = rem[BW-1:0];
         slot_in = q_ff[SW-1:0];
         if (mode_ff == MODE_FREE && !free_hit) bad_in = 1'b1;
         if (mode_ff == MODE_QUERY) owned_in = free_hit;
      end

      if (cmd.modify) begin
         if (mode_ff == MODE_ALLOC) begin
            new_mask            = rd_data_ff & ~iso;
            mem_we              = 1'b1;
            mem_wd              = new_mask;
            nonfull_in[slot_ff] = (new_mask != '0);
            bit_in              = low_bit;
            page_en_in          = 1'b1;
         end else if ((rd_data_ff & idx_bit) != '0) begin
            bad_in = 1'b1;
         end else begin
            new_mask = rd_data_ff | idx_bit;
            mem_we   = 1'b1;
            mem_wd   = new_mask;
            if (new_mask == FULL_MASK) begin
               valid_in[slot_ff]   = 1'b0;
               nonfull_in[slot_ff] = 1'b0;
               rel_in              = 1'b1;
            end else begin
               nonfull_in[slot_ff] = 1'b1;
            end
         end
      end
   end

   // result register: hold while stalled, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_owned_in  = rsp_owned_ff;
      rsp_acq_in    = rsp_acq_ff;
      rsp_rel_in    = rsp_rel_ff;
      if (cmd.load) begin
         rsp_valid_in  = 1'b1;
         rsp_page_in   = page_en_ff ? page_wide[PN_W-1:0] : '0;
         rsp_status_in = bad_ff ? RSP_BAD_FREE : (nospace_ff ? RSP_NO_SPACE : RSP_OK);
         rsp_owned_in  = owned_ff;
         rsp_acq_in    = acq_ff;
         rsp_rel_in    = rel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         nonfull_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         nonfull_ff   <= nonfull_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      pn_ff          <= pn_in;
      q_ff           <= q_in;
      idx_ff         <= idx_in;
      slot_ff        <= slot_in;
      bit_ff         <= bit_in;
      chunk_ff       <= chunk_in;
      found_avail_ff <= found_avail_in;
      found_empty_ff <= found_empty_in;
      avail_slot_ff  <= avail_slot_in;
      empty_slot_ff  <= empty_slot_in;
      bad_ff         <= bad_in;
      nospace_ff     <= nospace_in;
      owned_ff       <= owned_in;
      acq_ff         <= acq_in;
      rel_ff         <= rel_in;
      page_en_ff     <= page_en_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_owned_ff   <= rsp_owned_in;
      rsp_acq_ff     <= rsp_acq_in;
      rsp_rel_ff     <= rsp_rel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mask_ram[mem_wa] <= mem_wd;
      if (cmd.rd) rd_data_ff <= mask_ram[slot_ff];
   end

   assign stat.mode        = mode_ff;
   assign stat.last_chunk  = (chunk_ff == CW'(NCH - 1));
   assign stat.found_avail = found_avail_ff;
   assign stat.free_hit    = free_hit;
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_page_number_res = rsp_page_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_owned           = rsp_owned_ff;
   assign rsp_region_acquired = rsp_acq_ff;
   assign rsp_region_released = rsp_rel_ff;

   a_nonfull_implies_valid: assert property (@(posedge clock) disable iff (reset)
      (nonfull_ff & ~valid_ff) == '0)
      else $error("slot marked as having free pages while not valid");

   a_alloc_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.modify && mode_ff == MODE_ALLOC |-> rd_data_ff != '0)
      else $error("allocation reached a region with no free page");

   a_acq_rel_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_acq_ff && rsp_rel_ff))
      else $error("beat both acquires and releases a region");

   a_owned_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_owned_ff |-> rsp_status_ff == RSP_OK && !rsp_acq_ff && !rsp_rel_ff)
      else $error("ownership answer carries allocation side effects");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bitmap region page allocator: scoreboard, drivers and stimulus.
module tb_top;
   import brpa_pkg::*;

   localparam int SLOTS = 16;
   localparam int PAGES = 64;
   // Slowest correct run is roughly 650 beats; allow far more.
   localparam int TIMEOUT_CYCLES = 400000;
   // Give the tail after the last owed response a comfortable margin.
   localparam int TAIL_CYCLES = 24;
   localparam int LONG_HOLD_CYCLES = 90;
   localparam int MAX_PRINTED = 100;
   localparam int FILL_SLOTS = 2;
   localparam int DRAIN_SLOT = 1;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [PAGES-1:0] WHOLE_REGION_FREE = '1;
   localparam logic [PAGES-1:0] FRESH_REGION = {{(PAGES-1){1'b1}}, 1'b0};

   typedef struct packed {
      logic [PN_W-1:0]     page;
      logic [STATUS_W-1:0] status;
      logic                owned;
      logic                acquired;
      logic                released;
   } page_rsp_type;

   // Page map predictor plus the queue of responses still owed by the block.
   class page_alloc_scoreboard;
      bit               slot_live [SLOTS];
      logic [PAGES-1:0] slot_free [SLOTS];
      page_rsp_type     owed [$];
      int errors;
      int n_beats, n_granted, n_no_space, n_acquired, n_released, n_bad_free, n_owned;

      // Advance the page map by one accepted request beat and queue its response.
      function void note_request(logic [MODE_W-1:0] mode, logic [PN_W-1:0] pn);
         page_rsp_type e;
         int slot, idx, s, b, low;
         bit done;
         e = '0;
         slot = pn / PAGES;
         idx = pn % PAGES;
         done = 1'b0;
         n_beats++;
         case (mode)
            MODE_ALLOC: begin
               // lowest live region with a free page first, then the lowest unused slot
               for (s = 0; s < SLOTS; s++) begin
                  if (!done && slot_live[s] && slot_free[s] != '0) begin
                     low = 0;
                     for (b = PAGES - 1; b >= 0; b--)
                        if (slot_free[s][b]) low = b;
                     slot_free[s][low] = 1'b0;
                     e.page = PN_W'(s * PAGES + low);
                     done = 1'b1;
                  end
               end
               for (s = 0; s < SLOTS; s++) begin
                  if (!done && !slot_live[s]) begin
                     slot_live[s] = 1'b1;
                     slot_free[s] = FRESH_REGION;
                     e.page = PN_W'(s * PAGES);
                     e.acquired = 1'b1;
                     done = 1'b1;
                     n_acquired++;
                  end
               end
               if (done) n_granted++;
               else begin
                  e.status = RSP_NO_SPACE;
                  n_no_space++;
               end
            end
            MODE_FREE: begin
               if (slot >= SLOTS || !slot_live[slot] || slot_free[slot][idx]) begin
                  e.status = RSP_BAD_FREE;
                  n_bad_free++;
               end else begin
                  slot_free[slot][idx] = 1'b1;
                  if (slot_free[slot] == WHOLE_REGION_FREE) begin
                     slot_live[slot] = 1'b0;
                     e.released = 1'b1;
                     n_released++;
                  end
               end
            end
            MODE_QUERY: begin
               e.owned = (slot < SLOTS) && slot_live[slot];
               if (e.owned) n_owned++;
            end
            default: ;
         endcase
         owed.push_back(e);
      endfunction

      // Pick a random page that is handed out, within one slot or anywhere (sel < 0).
      function logic [PN_W-1:0] busy_page(int sel, output bit found);
         int n, k, s, p;
         logic [PN_W-1:0] pick;
         n = 0;
         pick = '0;
         for (s = 0; s < SLOTS; s++)
            if (slot_live[s] && (sel < 0 || sel == s))
               for (p = 0; p < PAGES; p++)
                  if (!slot_free[s][p]) n++;
         found = (n != 0);
         if (found) begin
            k = $urandom_range(0, n - 1);
            for (s = 0; s < SLOTS; s++)
               if (slot_live[s] && (sel < 0 || sel == s))
                  for (p = 0; p < PAGES; p++)
                     if (!slot_free[s][p]) begin
                        if (k == 0) pick = PN_W'(s * PAGES + p);
                        k--;
                     end
         end
         return pick;
      endfunction

      // True once the n lowest slots are all live with no free page left.
      function bit low_slots_full(int n);
         int s;
         for (s = 0; s < n; s++)
            if (!slot_live[s] || slot_free[s] != '0) return 1'b0;
         return 1'b1;
      endfunction

      task report(string msg);
         errors++;
         // keep the log short when the block is badly broken
         if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(page_rsp_type got);
         page_rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("response beat with nothing owed (page %0d status %0d)",
                             got.page, got.status));
            return;
         end
         want = owed.pop_front();
         if (got.page !== want.page)
            report($sformatf("page_number_res %0d, want %0d", got.page, want.page));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.owned !== want.owned)
            report($sformatf("owned %0b, want %0b", got.owned, want.owned));
         if (got.acquired !== want.acquired)
            report($sformatf("region_acquired %0b, want %0b", got.acquired, want.acquired));
         if (got.released !== want.released)
            report($sformatf("region_released %0b, want %0b", got.released, want.released));
      endtask
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_ALLOC;
   logic [PN_W-1:0]     req_page_number = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PN_W-1:0]     rsp_page_number_res;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_owned;
   logic                rsp_region_acquired;
   logic                rsp_region_released;

   page_alloc_scoreboard sb;
   int cycle_count = 0;
   int req_beats = 0;
   int rsp_beats = 0;
   int focus_slot = 0;

   bitmap_region_page_allocator_unit #(
      .REGION_SLOTS     (SLOTS),
      .PAGES_PER_REGION (PAGES)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_page_number     (req_page_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_page_number_res (rsp_page_number_res),
      .rsp_status          (rsp_status),
      .rsp_owned           (rsp_owned),
      .rsp_region_acquired (rsp_region_acquired),
      .rsp_region_released (rsp_region_released)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: abandon the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses owed", cycle_count, sb.owed.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request beat and hold it until the block takes it. Drive on the falling
   // edge, sample the stall on the rising edge. Valid stays high straight into the next
   // beat when the drawn gap is zero, so it is never lowered and raised in one step.
   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [PN_W-1:0] pn);
      int gap;
      // every fourth stretch of 40 beats goes back to back
      gap = ((req_beats / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_page_number <= pn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, pn);
      req_beats++;
   endtask

   // One random beat. Frees mostly hit pages that are handed out, and mostly in one focus
   // slot, so that regions actually drain and get released; the rest is noise that lands
   // on absent regions or pages already free.
   task automatic random_beat(input int alloc_pct);
      int r;
      bit ok;
      logic [PN_W-1:0] pn;
      r = $urandom_range(0, 99);
      pn = PN_W'($urandom);
      if (r < alloc_pct) begin
         send_beat(MODE_ALLOC, pn);
      end else if (r < 88) begin
         if ($urandom_range(0, 9) < 8) begin
            ok = 1'b0;
            if ($urandom_range(0, 9) < 7) pn = sb.busy_page(focus_slot, ok);
            if (!ok) begin
               pn = sb.busy_page(-1, ok);
               if (ok) focus_slot = pn / PAGES;
               else pn = PN_W'($urandom);
            end
         end
         send_beat(MODE_FREE, pn);
      end else if (r < 96) begin
         send_beat(MODE_QUERY, pn);
      end else begin
         send_beat(MODE_UNUSED, pn);
      end
   endtask

   task automatic random_phase(input int beats);
      int i, alloc_pct;
      alloc_pct = 50;
      for (i = 0; i < beats; i++) begin
         // switch at random between allocate-heavy and free-heavy bursts so occupancy swings widely
         if (i % 25 == 0) alloc_pct = $urandom_range(0, 1) ? 70 : 25;
         random_beat(alloc_pct);
      end
   endtask

   // Response side: draw a hold-off per beat, then take the next beat and check it.
   // Once in the run, hold off for a long stretch so the block backs up into its input.
   initial begin : rsp_side
      int hold;
      page_rsp_type got;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_beats == 120) hold = LONG_HOLD_CYCLES;
         else if ((rsp_beats / 50) % 4 == 2) hold = 0;
         else hold = $urandom_range(0, 5);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.page     = rsp_page_number_res;
         got.status   = rsp_status;
         got.owned    = rsp_owned;
         got.acquired = rsp_region_acquired;
         got.released = rsp_region_released;
         sb.check_response(got);
         rsp_beats++;
      end
   end

   initial begin : stimulus
      int i;
      bit ok;
      logic [PN_W-1:0] pn;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty map, absent regions, unused mode, open and release a slot,
      // reuse of the lowest free page, double free, free of a never-handed-out page.
      send_beat(MODE_QUERY, PN_W'(0));
      send_beat(MODE_FREE, PN_W'(0));
      send_beat(MODE_FREE, PN_W'(1023));
      send_beat(MODE_UNUSED, PN_W'(1023));
      send_beat(MODE_ALLOC, PN_W'(1023));
      send_beat(MODE_QUERY, PN_W'(63));
      send_beat(MODE_QUERY, PN_W'(64));
      send_beat(MODE_FREE, PN_W'(0));
      send_beat(MODE_QUERY, PN_W'(0));
      send_beat(MODE_ALLOC, PN_W'(0));
      send_beat(MODE_ALLOC, PN_W'(0));
      send_beat(MODE_ALLOC, PN_W'(0));
      send_beat(MODE_FREE, PN_W'(1));
      send_beat(MODE_FREE, PN_W'(1));
      send_beat(MODE_FREE, PN_W'(63));
      send_beat(MODE_ALLOC, PN_W'(0));
      send_beat(MODE_UNUSED, PN_W'(0));
      send_beat(MODE_QUERY, PN_W'(1023));

      random_phase(150);

      // Fill the lowest regions to the brim so later allocations have to skip them.
      i = 0;
      while (!sb.low_slots_full(FILL_SLOTS) && i < 2 * FILL_SLOTS * PAGES) begin
         send_beat(MODE_ALLOC, PN_W'($urandom));
         i++;
      end
      repeat (3) send_beat(MODE_ALLOC, PN_W'($urandom));
      send_beat(MODE_QUERY, PN_W'(1023));

      // Drain one region in random order until its slot is released, then hit it again.
      pn = sb.busy_page(DRAIN_SLOT, ok);
      while (ok) begin
         send_beat(MODE_FREE, pn);
         pn = sb.busy_page(DRAIN_SLOT, ok);
      end
      send_beat(MODE_FREE, PN_W'(DRAIN_SLOT * PAGES));
      send_beat(MODE_QUERY, PN_W'(DRAIN_SLOT * PAGES + 17));
      send_beat(MODE_ALLOC, PN_W'($urandom));

      random_phase(150);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats: %0d pages granted, %0d no-space answers,",
               sb.n_beats, sb.n_granted, sb.n_no_space);
      $display("%0d slots opened, %0d released, %0d bad frees, %0d owned queries; %0d mismatches.",
               sb.n_acquired, sb.n_released, sb.n_bad_free, sb.n_owned, sb.errors);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
